// ===== rtl/core/mspid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspid_pkg
// shared types, constants and helpers for the motor speed pid controller
// ----------------------------------------------------------------------------
package mspid_pkg;

  // parameter defaults
  localparam int PERIOD_BITS_DEFAULT        = 16;
  localparam int GAIN_FRACTION_BITS_DEFAULT = 8;

  // field widths
  localparam int PERIOD_W = 16;
  localparam int SPEED_W  = 16;
  localparam int DUTY_W   = 8;
  localparam int GAIN_W   = 16;
  localparam int ERR_W    = 16;
  localparam int CFG_W    = 16;

  // speed = SPEED_NUMERATOR / period, numerator is 16e6 / 1024 * 60
  localparam int                 NUM_W           = 20;
  localparam logic [NUM_W-1:0]   SPEED_NUMERATOR = 20'd937500;
  localparam logic [SPEED_W-1:0] SPEED_MAX       = 16'hFFFF;
  localparam logic [DUTY_W-1:0]  DUTY_MAX        = 8'd255;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_REFERENCE_SPEED   = 2'd0,
    REG_GAIN_PROPORTIONAL = 2'd1,
    REG_GAIN_INTEGRAL     = 2'd2,
    REG_GAIN_DERIVATIVE   = 2'd3
  } cfg_reg_t;

  // direction of the error change
  typedef enum logic [1:0] {
    DIR_NONE    = 2'd0,
    DIR_RISING  = 2'd1,
    DIR_FALLING = 2'd2
  } direction_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] rotation_period;
  } tick_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  pwm_duty;
    logic [SPEED_W-1:0] measured_speed;
  } result_item_t;

  // saturate a signed value to 16 bits
  function automatic logic signed [ERR_W-1:0] sat16(input logic signed [ERR_W+1:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mspid_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspid_stream_if
// valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface mspid_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mspid_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspid_divider
// radix-2 restoring divider: speed numerator over the period, one quotient
// bit a cycle, result zero for a zero period and saturated to 16 bits
// ----------------------------------------------------------------------------
module mspid_divider #(
  parameter int PERIOD_BITS = mspid_pkg::PERIOD_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [PERIOD_BITS-1:0]         divisor,
  output logic                                done,
  output logic [mspid_pkg::SPEED_W-1:0]       speed
);

  localparam int NUM_W = mspid_pkg::NUM_W;
  localparam int CNT_W = $clog2(NUM_W);

  logic                   busy;
  logic [CNT_W-1:0]       count;
  logic [PERIOD_BITS-1:0] div_reg;
  logic                   div_zero;
  logic [PERIOD_BITS-1:0] rem;
  logic [NUM_W-1:0]       num_sr;
  logic [NUM_W-1:0]       quot;

  logic [PERIOD_BITS:0]   rem_shift;
  logic                   fits;
  logic [PERIOD_BITS:0]   rem_sub;
  logic [NUM_W-1:0]       quot_next;

  always_comb begin
    rem_shift = {rem, num_sr[NUM_W-1]};
    fits      = rem_shift >= {1'b0, div_reg};
    rem_sub   = rem_shift - {1'b0, div_reg};
    quot_next = {quot[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_reg  <= divisor;
      div_zero <= (divisor == '0);
      rem      <= '0;
      num_sr   <= mspid_pkg::SPEED_NUMERATOR;
      quot     <= '0;
    end else if (busy) begin
      // remainder stays below the divisor, so the top bit drops away
      rem    <= fits ? rem_sub[PERIOD_BITS-1:0] : rem_shift[PERIOD_BITS-1:0];
      num_sr <= {num_sr[NUM_W-2:0], 1'b0};
      quot   <= quot_next;
    end
  end

  always_comb begin
    if (div_zero) begin
      speed = '0;
    end else if (quot[NUM_W-1:mspid_pkg::SPEED_W] != '0) begin
      speed = mspid_pkg::SPEED_MAX;
    end else begin
      speed = quot[mspid_pkg::SPEED_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/motor_speed_pid_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// motor_speed_pid_controller
// pid speed loop: tachometer period in, pwm duty and measured rpm out
// ----------------------------------------------------------------------------
// Each transfer on tick carries the period of one revolution in prescaled
// timer ticks (only its low PERIOD_BITS bits count, zero means stopped) and
// produces exactly one transfer on result with the pwm duty (0..255) and the
// speed in rpm (937500 / period, 0 for a stopped motor, saturated at 65535).
// An item passes from its transfer in through the one-bit-a-cycle divider,
// a step that takes its quotient, a step for the error, a step for the
// error change and the integral update, the single 17x17 multiplier that
// forms the proportional, integral and derivative products one after
// another and adds them up, and a last step that loads the output
// register. tick is ready only while no item is in work; a
// finished result sits in the output register, so the next tick is taken
// while it waits. The integral is cleared whenever the direction of the
// error change differs from the previous tick, and on the first tick after
// reset only the proportional term drives the output. Error and integral
// saturate to signed 16 bits. Configuration writes (index 0 reference speed,
// 1..3 the Q-format proportional, integral and derivative gains) take effect
// at once and belong between items.
// ----------------------------------------------------------------------------
module motor_speed_pid_controller #(
  parameter int PERIOD_BITS        = mspid_pkg::PERIOD_BITS_DEFAULT,
  parameter int GAIN_FRACTION_BITS = mspid_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [mspid_pkg::CFG_W-1:0] cfg_data,
  mspid_stream_if.sink                   tick,
  mspid_stream_if.source                 result
);

  localparam int ERR_W  = mspid_pkg::ERR_W;
  localparam int GAIN_W = mspid_pkg::GAIN_W;
  localparam int OP_W   = ERR_W + 1;           // signed operand width
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = PROD_W + 2;          // three products summed
  localparam int EXT_W  = (PERIOD_BITS > mspid_pkg::PERIOD_W) ?
                          PERIOD_BITS : mspid_pkg::PERIOD_W;

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_ERR   = 9'b000000100,
    S_UPD   = 9'b000001000,
    S_MUL_P = 9'b000010000,
    S_MUL_I = 9'b000100000,
    S_MUL_D = 9'b001000000,
    S_ACC   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [mspid_pkg::SPEED_W-1:0] reference_speed;
  logic [GAIN_W-1:0]             gain_proportional;
  logic [GAIN_W-1:0]             gain_integral;
  logic [GAIN_W-1:0]             gain_derivative;

  // loop state
  logic                          first_tick;
  logic signed [ERR_W-1:0]       previous_error;
  mspid_pkg::direction_t         previous_direction;
  logic signed [ERR_W-1:0]       error_sum;

  // per-item work registers
  logic [mspid_pkg::SPEED_W-1:0] speed;
  logic signed [ERR_W-1:0]       error;
  logic signed [OP_W-1:0]        change;
  logic                          item_first;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;

  // divider hookup
  logic                          div_start;
  logic                          div_done;
  logic [EXT_W-1:0]              period_ext;
  logic [mspid_pkg::SPEED_W-1:0] div_speed;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_speed   <= 16'd1000;
      gain_proportional <= 16'd256;
      gain_integral     <= '0;
      gain_derivative   <= '0;
    end else if (cfg_we) begin
      case (mspid_pkg::cfg_reg_t'(cfg_index))
        mspid_pkg::REG_REFERENCE_SPEED:   reference_speed   <= cfg_data;
        mspid_pkg::REG_GAIN_PROPORTIONAL: gain_proportional <= cfg_data;
        mspid_pkg::REG_GAIN_INTEGRAL:     gain_integral     <= cfg_data;
        mspid_pkg::REG_GAIN_DERIVATIVE:   gain_derivative   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- period to speed ----------------
  assign tick.ready = (state == S_IDLE);
  assign div_start  = tick.valid && tick.ready;
  // only the low PERIOD_BITS bits of the period are used
  assign period_ext = EXT_W'(tick.payload.rotation_period);

  mspid_divider #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (period_ext[PERIOD_BITS-1:0]),
    .done    (div_done),
    .speed   (div_speed)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (div_start) state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_ERR;
      S_ERR:   state_next = S_UPD;
      S_UPD:   state_next = S_MUL_P;
      S_MUL_P: state_next = S_MUL_I;
      S_MUL_I: state_next = S_MUL_D;
      S_MUL_D: state_next = S_ACC;
      S_ACC:   state_next = S_OUT;
      S_OUT:   if (!result.valid || result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- error, change and integral ----------------
  logic signed [OP_W-1:0]     diff_ref;
  logic signed [OP_W-1:0]     change_next;
  logic signed [OP_W-1:0]     sum_raw;
  mspid_pkg::direction_t      direction;

  always_comb begin
    diff_ref    = signed'({1'b0, reference_speed}) - signed'({1'b0, speed});
    change_next = OP_W'(error) - OP_W'(previous_error);
    sum_raw     = OP_W'(error_sum) + OP_W'(error);
    if (change_next > 0) begin
      direction = mspid_pkg::DIR_RISING;
    end else if (change_next < 0) begin
      direction = mspid_pkg::DIR_FALLING;
    end else begin
      direction = mspid_pkg::DIR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      speed <= div_speed;
    end
    if (state == S_ERR) begin
      error <= mspid_pkg::sat16((ERR_W + 2)'(diff_ref));
    end
    if (state == S_UPD) begin
      change     <= change_next;
      item_first <= first_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_tick         <= 1'b1;
      previous_error     <= '0;
      previous_direction <= mspid_pkg::DIR_NONE;
      error_sum          <= '0;
    end else if (state == S_UPD) begin
      // first tick only records the error
      if (!first_tick) begin
        if (direction == previous_direction) begin
          error_sum <= mspid_pkg::sat16((ERR_W + 2)'(sum_raw));
        end else begin
          error_sum <= '0;
        end
        previous_direction <= direction;
      end
      previous_error <= error;
      first_tick     <= 1'b0;
    end
  end

  // ---------------- shared multiplier and accumulator ----------------
  logic [GAIN_W-1:0]      mul_gain;
  logic signed [OP_W-1:0] mul_a;
  logic signed [OP_W-1:0] mul_b;

  always_comb begin
    mul_gain = gain_proportional;
    mul_b    = OP_W'(error);
    case (state)
      S_MUL_I: begin
        mul_gain = item_first ? '0 : gain_integral;
        mul_b    = OP_W'(error_sum);
      end
      S_MUL_D: begin
        mul_gain = item_first ? '0 : gain_derivative;
        mul_b    = change;
      end
      default: begin
        mul_gain = gain_proportional;
        mul_b    = OP_W'(error);
      end
    endcase
    mul_a = signed'({1'b0, mul_gain});
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL_P || state == S_MUL_I || state == S_MUL_D) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_MUL_P) begin
      acc <= '0;
    end else if (state == S_MUL_I || state == S_MUL_D || state == S_ACC) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // ---------------- duty and output register ----------------
  logic [ACC_W-1:0]                 acc_whole;
  logic [mspid_pkg::DUTY_W-1:0]     duty;

  always_comb begin
    acc_whole = unsigned'(acc) >> GAIN_FRACTION_BITS;
    if (acc[ACC_W-1] || acc == '0) begin
      duty = '0;
    end else if (acc_whole > ACC_W'(mspid_pkg::DUTY_MAX)) begin
      duty = mspid_pkg::DUTY_MAX;
    end else begin
      duty = acc_whole[mspid_pkg::DUTY_W-1:0];
    end
  end

  logic out_load;
  assign out_load = (state == S_OUT) && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.payload.pwm_duty       <= duty;
      result.payload.measured_speed <= speed;
    end
  end

endmodule
`default_nettype wire
